FILE: sv/grm_pkg.sv
// Package with shared types, constants and action codes for the rectangle merger.
`timescale 1ns / 1ps
`default_nettype none
package grm_pkg;
    localparam int GRID_SIDE_DEF = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam int EDGE_W = 17;
    localparam logic [7:0] ALPHA_MASK = 8'hFF;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_LOAD = 2'd1,
        ACT_REQUEST = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_STEP = 3'd2,
        REG_QUAD = 3'd3,
        REG_MERGE = 3'd4,
        REG_CENTRE = 3'd5,
        REG_SPARE6 = 3'd6,
        REG_SPARE7 = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic [10:0] image_width;
        logic [10:0] image_height;
        logic [4:0] pixel_step;
        logic [10:0] quad_size;
        logic merge_enable;
        logic centre_at_origin;
    } t_cfg;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_in_word;

    typedef struct packed {
        logic [EDGE_W-1:0] left;
        logic [EDGE_W-1:0] top;
        logic [EDGE_W-1:0] right;
        logic [EDGE_W-1:0] bottom;
        logic [EDGE_W-1:0] centre_x;
        logic [EDGE_W-1:0] centre_y;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic done_res;
    } t_out_word;
endpackage
`default_nettype wire

FILE: sv/grm_if.sv
// Valid/ready channel interfaces for input words, result words and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface grm_in_if
    import grm_pkg::*;
;
    logic valid;
    logic ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface grm_out_if
    import grm_pkg::*;
;
    logic valid;
    logic ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface grm_cfg_if
    import grm_pkg::*;
;
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: sv/grm_regs.sv
// Configuration register file with write port.
`timescale 1ns / 1ps
`default_nettype none
module grm_regs
    import grm_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    grm_cfg_if.sink cfg,
    output t_cfg o_cfg
);
    t_cfg r_cfg;

    assign cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width <= 11'd64;
            r_cfg.image_height <= 11'd64;
            r_cfg.pixel_step <= 5'd1;
            r_cfg.quad_size <= 11'd1;
            r_cfg.merge_enable <= 1'b1;
            r_cfg.centre_at_origin <= 1'b0;
        end else if (cfg.valid) begin
            case (t_reg_index'(cfg.index))
                REG_WIDTH: r_cfg.image_width <= cfg.wdata;
                REG_HEIGHT: r_cfg.image_height <= cfg.wdata;
                REG_STEP: r_cfg.pixel_step <= cfg.wdata[4:0];
                REG_QUAD: r_cfg.quad_size <= cfg.wdata;
                REG_MERGE: r_cfg.merge_enable <= cfg.wdata[0];
                REG_CENTRE: r_cfg.centre_at_origin <= cfg.wdata[0];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: sv/grm_core.sv
// Sequencer that loads the sample grid and walks grid and covered map for rectangles.
`timescale 1ns / 1ps
`default_nettype none
module grm_core
    import grm_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire t_cfg i_cfg,
    grm_in_if.sink in_ch,
    grm_out_if.source out_ch
);
    localparam int CW = $clog2(GRID_SIDE);
    localparam int CNT_W = CW + 1;
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW = 2 * CW;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_CLEAR, S_SCAN, S_SCAN_CHK, S_RIGHT, S_RIGHT_CHK,
        S_DOWN, S_DOWN_CHK, S_MARK, S_MUL, S_SUM, S_OUT, S_RESYNC
    } t_state;

    // Storage: colours and covered flags.
    logic [31:0] r_grid [CELLS];
    logic r_cov [CELLS];
    logic [31:0] r_grid_q;
    logic r_cov_q;
    logic r_grid_we, r_cov_we;
    logic [AW-1:0] r_grid_wa, r_rd_a, r_cov_wa;
    logic [31:0] r_grid_wd;
    logic r_cov_wd;

    always_ff @(posedge i_clk) begin
        if (r_grid_we) r_grid[r_grid_wa] <= r_grid_wd;
        r_grid_q <= r_grid[r_rd_a];
    end
    always_ff @(posedge i_clk) begin
        if (r_cov_we) r_cov[r_cov_wa] <= r_cov_wd;
        r_cov_q <= r_cov[r_rd_a];
    end

    t_state r_state;
    logic [10:0] r_lx, r_ly;
    logic [4:0] r_sx, r_sy;         // position modulo the step
    logic [10:0] r_gx, r_gy;        // sampled column and row of the load position
    logic [4:0] r_step_used;        // stride that r_sx/r_sy/r_gx/r_gy were built with
    logic [10:0] r_rx, r_ry;        // remainders while re-dividing the load position
    logic [CNT_W-1:0] r_col, r_row; // scan position
    logic [CNT_W-1:0] r_across, r_down;
    logic [11:0] r_num;
    logic [11:0] r_qcnt;
    logic r_div_h;
    logic [CNT_W-1:0] r_c0, r_r0, r_wide, r_tall, r_i, r_k;
    logic [31:0] r_colour;
    logic r_whole;
    logic [AW:0] r_clr;
    logic [10:0] r_size;
    logic [27:0] r_l, r_t, r_w, r_h;
    t_out_word r_out;
    logic r_ovalid;

    logic [4:0] w_step;
    assign w_step = (i_cfg.pixel_step == 5'd0) ? 5'd1 : i_cfg.pixel_step;

    // Result word that marks an exhausted scan.
    t_out_word w_done_word;
    always_comb begin
        w_done_word = '0;
        w_done_word.done_res = 1'b1;
    end

    function automatic logic [AW-1:0] f_addr(input logic [CNT_W-1:0] c,
                                             input logic [CNT_W-1:0] r);
        f_addr = {r[CW-1:0], c[CW-1:0]};
    endfunction

    assign in_ch.ready = (r_state == S_IDLE) && (w_step == r_step_used) &&
                         !(r_ovalid && !out_ch.ready);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data = r_out;

    logic w_take;
    assign w_take = in_ch.valid && in_ch.ready;

    // A pixel word that lands on a sampled cell inside the grid.
    logic w_load_hit;
    assign w_load_hit = w_take && (t_action'(in_ch.data.action) == ACT_LOAD) &&
                        (r_ly < i_cfg.image_height) && (r_lx < i_cfg.image_width) &&
                        (r_sx == 5'd0) && (r_sy == 5'd0) &&
                        (r_gx < 11'(GRID_SIDE)) && (r_gy < 11'(GRID_SIDE));

    logic [10:0] w_nlx;
    assign w_nlx = r_lx + 11'd1;

    // Main sequencer: one memory read per probe; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_we <= 1'b0;
            r_cov_we <= 1'b0;
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_lx <= '0; r_ly <= '0; r_sx <= '0; r_sy <= '0; r_gx <= '0; r_gy <= '0;
            r_col <= '0; r_row <= '0;
            r_step_used <= 5'd1;
        end else begin
            r_grid_we <= w_load_hit;
            r_cov_we <= (r_state == S_CLEAR) || (r_state == S_MARK);
            if (r_ovalid && out_ch.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_step != r_step_used) begin
                        // Stride changed: rebuild the sampled load position.
                        r_rx <= r_lx; r_ry <= r_ly;
                        r_gx <= '0; r_gy <= '0;
                        r_state <= S_RESYNC;
                    end else if (w_take) begin
                        case (t_action'(in_ch.data.action))
                            ACT_START: begin
                                r_lx <= '0; r_ly <= '0; r_sx <= '0; r_sy <= '0;
                                r_gx <= '0; r_gy <= '0; r_col <= '0; r_row <= '0;
                                r_clr <= '0;
                                r_state <= S_CLEAR;
                            end
                            ACT_LOAD: begin
                                if (r_ly < i_cfg.image_height) begin
                                    if (w_load_hit) begin
                                        r_grid_wa <= {r_gy[CW-1:0], r_gx[CW-1:0]};
                                        r_grid_wd <= {in_ch.data.red, in_ch.data.green,
                                                      in_ch.data.blue, in_ch.data.alpha};
                                    end
                                    if (w_nlx >= i_cfg.image_width) begin
                                        r_lx <= '0; r_sx <= '0; r_gx <= '0;
                                        r_ly <= r_ly + 11'd1;
                                        if (r_sy + 5'd1 >= w_step) begin
                                            r_sy <= '0; r_gy <= r_gy + 11'd1;
                                        end else r_sy <= r_sy + 5'd1;
                                    end else begin
                                        r_lx <= w_nlx;
                                        if (r_sx + 5'd1 >= w_step) begin
                                            r_sx <= '0; r_gx <= r_gx + 11'd1;
                                        end else r_sx <= r_sx + 5'd1;
                                    end
                                end
                            end
                            ACT_REQUEST: begin
                                r_num <= {1'b0, i_cfg.image_width};
                                r_qcnt <= '0;
                                r_div_h <= 1'b0;
                                r_size <= (i_cfg.quad_size == 11'd0) ? 11'd1
                                                                     : i_cfg.quad_size;
                                r_state <= S_DIV;
                            end
                            default: ;
                        endcase
                    end
                end
                // Load position divided by the new stride, by repeated subtraction.
                S_RESYNC: begin
                    if (r_rx >= 11'(w_step)) begin
                        r_rx <= r_rx - 11'(w_step);
                        r_gx <= r_gx + 11'd1;
                    end
                    if (r_ry >= 11'(w_step)) begin
                        r_ry <= r_ry - 11'(w_step);
                        r_gy <= r_gy + 11'd1;
                    end
                    if (r_rx < 11'(w_step) && r_ry < 11'(w_step)) begin
                        r_sx <= r_rx[4:0];
                        r_sy <= r_ry[4:0];
                        r_step_used <= w_step;
                        r_state <= S_IDLE;
                    end
                end
                // Grid extents by repeated subtraction, capped at the grid side.
                S_DIV: begin
                    if (r_num == 12'd0 || r_qcnt >= 12'(GRID_SIDE)) begin
                        if (!r_div_h) begin
                            r_across <= CNT_W'(r_qcnt);
                            r_num <= {1'b0, i_cfg.image_height};
                            r_qcnt <= '0;
                            r_div_h <= 1'b1;
                        end else begin
                            r_down <= CNT_W'(r_qcnt);
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_qcnt <= r_qcnt + 12'd1;
                        r_num <= (r_num > 12'(w_step)) ? r_num - 12'(w_step) : 12'd0;
                    end
                end
                // Covered map clear sweep, one entry a cycle.
                S_CLEAR: begin
                    r_cov_wa <= r_clr[AW-1:0];
                    r_cov_wd <= 1'b0;
                    r_clr <= r_clr + 1'b1;
                    if (r_clr[AW-1:0] == {AW{1'b1}}) r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_row >= r_down) begin
                        r_out <= w_done_word;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_col >= r_across) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_rd_a <= f_addr(r_col, r_row);
                        r_c0 <= r_col; r_r0 <= r_row;
                        r_col <= r_col + 1'b1;
                        r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: r_state <= S_RIGHT; // read in flight
                S_RIGHT: begin
                    // r_grid_q/r_cov_q now hold the start cell.
                    if (r_cov_q || r_grid_q[7:0] == 8'd0) r_state <= S_SCAN;
                    else begin
                        r_colour <= r_grid_q;
                        r_wide <= CNT_W'(1); r_tall <= CNT_W'(1);
                        if (!i_cfg.merge_enable) r_state <= S_MUL;
                        else if (r_c0 + 1'b1 < r_across) begin
                            r_rd_a <= f_addr(r_c0 + 1'b1, r_r0);
                            r_state <= S_RIGHT_CHK;
                        end else if (r_r0 + 1'b1 < r_down) begin
                            r_i <= '0; r_whole <= 1'b0;
                            r_rd_a <= f_addr(r_c0, r_r0 + 1'b1);
                            r_state <= S_DOWN_CHK;
                        end else begin
                            r_i <= '0; r_k <= '0; r_state <= S_MARK;
                        end
                    end
                end
                S_RIGHT_CHK: r_state <= S_DOWN;
                // Grow right: data for column c0+wide arrives here.
                S_DOWN: begin
                    if (!r_cov_q && r_grid_q == r_colour) begin
                        r_wide <= r_wide + 1'b1;
                        if (r_c0 + r_wide + 1'b1 < r_across) begin
                            r_rd_a <= f_addr(r_c0 + r_wide + 1'b1, r_r0);
                            r_state <= S_RIGHT_CHK;
                        end else if (r_r0 + 1'b1 < r_down) begin
                            r_i <= '0;
                            r_rd_a <= f_addr(r_c0, r_r0 + 1'b1);
                            r_state <= S_DOWN_CHK;
                            r_whole <= 1'b0;
                        end else begin
                            r_i <= '0; r_k <= '0; r_state <= S_MARK;
                        end
                    end else if (r_r0 + 1'b1 < r_down) begin
                        r_i <= '0;
                        r_rd_a <= f_addr(r_c0, r_r0 + 1'b1);
                        r_state <= S_DOWN_CHK;
                        r_whole <= 1'b0;
                    end else begin
                        r_i <= '0; r_k <= '0; r_state <= S_MARK;
                    end
                end
                // Grow down: r_whole marks the cycle where read data is valid.
                S_DOWN_CHK: begin
                    if (!r_whole) r_whole <= 1'b1;
                    else begin
                        r_whole <= 1'b0;
                        if (r_cov_q || r_grid_q != r_colour) begin
                            r_i <= '0; r_k <= '0; r_state <= S_MARK;
                        end else if (r_i + 1'b1 < r_wide) begin
                            r_i <= r_i + 1'b1;
                            r_rd_a <= f_addr(r_c0 + r_i + 1'b1, r_r0 + r_tall);
                        end else begin
                            r_tall <= r_tall + 1'b1;
                            r_i <= '0;
                            if (r_r0 + r_tall + 1'b1 < r_down)
                                r_rd_a <= f_addr(r_c0, r_r0 + r_tall + 1'b1);
                            else begin
                                r_k <= '0; r_state <= S_MARK;
                            end
                        end
                    end
                end
                // Mark covered cells, one a cycle.
                S_MARK: begin
                    r_cov_wa <= f_addr(r_c0 + r_i, r_r0 + r_k);
                    r_cov_wd <= 1'b1;
                    if (r_i + 1'b1 < r_wide) r_i <= r_i + 1'b1;
                    else begin
                        r_i <= '0;
                        r_k <= r_k + 1'b1;
                        if (r_k + 1'b1 >= r_tall) r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_l <= 28'(r_c0) * 28'(r_size);
                    r_t <= 28'(r_r0) * 28'(r_size);
                    r_w <= 28'(r_wide) * 28'(r_size);
                    r_h <= 28'(r_tall) * 28'(r_size);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_w <= r_l + r_w;
                    r_h <= r_t + r_h;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out.left <= r_l[EDGE_W-1:0];
                    r_out.top <= r_t[EDGE_W-1:0];
                    r_out.right <= r_w[EDGE_W-1:0];
                    r_out.bottom <= r_h[EDGE_W-1:0];
                    r_out.centre_x <= i_cfg.centre_at_origin ? '0
                                    : EDGE_W'(({1'b0, r_l} + {1'b0, r_w}) >> 1);
                    r_out.centre_y <= i_cfg.centre_at_origin ? '0
                                    : EDGE_W'(({1'b0, r_t} + {1'b0, r_h}) >> 1);
                    r_out.out_red <= r_colour[31:24];
                    r_out.out_green <= r_colour[23:16];
                    r_out.out_blue <= r_colour[15:8];
                    r_out.out_alpha <= r_colour[7:0] & ALPHA_MASK;
                    r_out.done_res <= 1'b0;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: sv/greedy_rectangle_merger.sv
// Rectangle merger top level.
// A start word also clears the covered map. A stride change stalls input while the
// load position is re-divided. A request sizes the grid, scans the cells, probes cells
// to grow each rectangle right and down, marks the covered cells and scales the edges
// by multiply, sum and output steps. One word is in flight at a time. Reset is
// synchronous and active low; after reset the covered map is cleared, taking no word.
`timescale 1ns / 1ps
`default_nettype none
module greedy_rectangle_merger
    import grm_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    grm_cfg_if.sink cfg,
    grm_in_if.sink in_ch,
    grm_out_if.source out_ch
);
    t_cfg w_cfg;

    grm_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg(cfg), .o_cfg(w_cfg)
    );

    grm_core #(.GRID_SIDE(GRID_SIDE)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(w_cfg), .in_ch(in_ch), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

FILE: sv/grm_checker.sv
// Port-level checker for the rectangle merger, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module grm_checker
    import grm_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic done_res,
    input wire logic [EDGE_W-1:0] left,
    input wire logic [EDGE_W-1:0] right
);
    // A finished word holds until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    // A done word carries zero edges.
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && done_res |-> left == '0 && right == '0) else $error("done not zero");
    // No input is taken while a result is stalled.
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("input while stalled");
    // A new result never shows up on the cycle right after an accepted word.
    a_accept_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid || $past(out_valid))
        else $error("result without work");
endmodule

bind greedy_rectangle_merger grm_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .done_res(out_ch.data.done_res),
    .left(out_ch.data.left), .right(out_ch.data.right)
);
`default_nettype wire
